/* hdl/color_angle_pixel_classifier_macros.svh */
// Assertion macros for the checks in the top level of this block.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef COLOR_ANGLE_PIXEL_CLASSIFIER_MACROS_SVH
`define COLOR_ANGLE_PIXEL_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CAP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define CAP_ASSERT_SAME(label, ante, cons)
`define CAP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/cap_pkg.sv */
package cap_pkg;

    // Field and arithmetic widths.
    localparam int CHAN_W     = 8;
    localparam int SQ_W       = 18;
    localparam int COS_W      = 16;
    localparam int C2_W       = 30;
    localparam int PROD_W     = 36;
    localparam int HALF_W     = PROD_W / 2;
    localparam int PART_W     = HALF_W + C2_W;
    localparam int FRAC_W     = 30;
    localparam int CMP_W      = PROD_W + FRAC_W;

    // Pipeline, queue and credit sizing.
    localparam int PIPE_DEPTH = 4;
    localparam int PCNT_W     = $clog2(PIPE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CAPACITY   = PIPE_DEPTH + QUEUE_DEPTH;
    localparam int TOKEN_W    = $clog2(CAPACITY + 1);

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [COS_W-1:0] COS_RESET = 16'd32270;

    // Painting value for a saturated channel.
    localparam logic [CHAN_W-1:0] PAINT_FULL = 8'hFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REF1_RED      = 3'd0,
        REG_REF1_GREEN    = 3'd1,
        REG_REF1_BLUE     = 3'd2,
        REG_REF2_RED      = 3'd3,
        REG_REF2_GREEN    = 3'd4,
        REG_REF2_BLUE     = 3'd5,
        REG_COS_THRESHOLD = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] pixel_red;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_blue;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              match_first;
        logic              match_second;
    } result_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } ref_color_t;

    // A classified pixel travelling from the front end to the back end.
    typedef struct packed {
        pixel_t pixel;
        logic   match_first;
        logic   match_second;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic              full;
    } queue_stat_t;

    typedef struct packed {
        logic [PCNT_W-1:0] count;
    } front_stat_t;

endpackage

/* hdl/cap_angle.sv */
module cap_angle
    import cap_pkg::*;
(
    input  logic                    clk,
    input  pixel_t                  pixel,
    input  ref_color_t              ref_color,
    input  logic signed [COS_W-1:0] cos_threshold,
    output logic                    match
);

    // Stage one: squared norms, dot product and squared cosine.
    logic [SQ_W-1:0] p2_next, r2_next, dot_next;
    logic [C2_W-1:0] c2_next;
    logic [SQ_W-1:0] p2_reg, r2_reg, dot_reg;
    logic [C2_W-1:0] c2_s1_reg;
    logic            cneg_s1_reg;

    always_comb
    begin
        p2_next = SQ_W'(pixel.pixel_red) * SQ_W'(pixel.pixel_red)
                + SQ_W'(pixel.pixel_green) * SQ_W'(pixel.pixel_green)
                + SQ_W'(pixel.pixel_blue) * SQ_W'(pixel.pixel_blue);
        r2_next = SQ_W'(ref_color.red) * SQ_W'(ref_color.red)
                + SQ_W'(ref_color.green) * SQ_W'(ref_color.green)
                + SQ_W'(ref_color.blue) * SQ_W'(ref_color.blue);
        dot_next = SQ_W'(pixel.pixel_red) * SQ_W'(ref_color.red)
                 + SQ_W'(pixel.pixel_green) * SQ_W'(ref_color.green)
                 + SQ_W'(pixel.pixel_blue) * SQ_W'(ref_color.blue);
        c2_next = C2_W'(cos_threshold[COS_W-2:0]) * C2_W'(cos_threshold[COS_W-2:0]);
    end

    always_ff @(posedge clk)
    begin
        p2_reg      <= p2_next;
        r2_reg      <= r2_next;
        dot_reg     <= dot_next;
        c2_s1_reg   <= c2_next;
        cneg_s1_reg <= cos_threshold[COS_W-1];
    end

    // Stage two: squared dot product and product of the norms.
    logic [PROD_W-1:0] dsq_next, pr2_next;
    logic [PROD_W-1:0] dsq_s2_reg, pr2_reg;
    logic [C2_W-1:0]   c2_s2_reg;
    logic              cneg_s2_reg, nonzero_s2_reg;

    always_comb
    begin
        dsq_next = PROD_W'(dot_reg) * PROD_W'(dot_reg);
        pr2_next = PROD_W'(p2_reg) * PROD_W'(r2_reg);
    end

    always_ff @(posedge clk)
    begin
        dsq_s2_reg     <= dsq_next;
        pr2_reg        <= pr2_next;
        c2_s2_reg      <= c2_s1_reg;
        cneg_s2_reg    <= cneg_s1_reg;
        nonzero_s2_reg <= (p2_reg != '0) && (r2_reg != '0);
    end

    // Stage three: norm product times squared cosine, split into two halves.
    logic [PART_W-1:0] lo_next, hi_next;
    logic [PART_W-1:0] lo_reg, hi_reg;
    logic [PROD_W-1:0] dsq_s3_reg;
    logic              cneg_s3_reg, nonzero_s3_reg;

    always_comb
    begin
        lo_next = PART_W'(pr2_reg[HALF_W-1:0]) * PART_W'(c2_s2_reg);
        hi_next = PART_W'(pr2_reg[PROD_W-1:HALF_W]) * PART_W'(c2_s2_reg);
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        dsq_s3_reg     <= dsq_s2_reg;
        cneg_s3_reg    <= cneg_s2_reg;
        nonzero_s3_reg <= nonzero_s2_reg;
    end

    // Stage four: join the halves and compare against the scaled squared dot.
    // A negative threshold admits every nonzero pair, as the dot is never negative.
    logic [CMP_W-1:0] lhs, rhs;
    logic             match_next, match_reg;

    always_comb
    begin
        rhs        = (CMP_W'(hi_reg) << HALF_W) + CMP_W'(lo_reg);
        lhs        = CMP_W'(dsq_s3_reg) << FRAC_W;
        match_next = nonzero_s3_reg && (cneg_s3_reg || (lhs > rhs));
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign match = match_reg;

endmodule

/* hdl/cap_front.sv */
module cap_front
    import cap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  pixel_t                  pixel,
    input  ref_color_t              ref1,
    input  ref_color_t              ref2,
    input  logic signed [COS_W-1:0] cos_threshold,
    output item_t                   item,
    output logic                    item_valid,
    output front_stat_t             front_stat
);

    logic match_first, match_second;

    // One angle test per reference colour, both running in lock step.
    cap_angle u_angle_first
    (
        .clk           (clk),
        .pixel         (pixel),
        .ref_color     (ref1),
        .cos_threshold (cos_threshold),
        .match         (match_first)
    );

    cap_angle u_angle_second
    (
        .clk           (clk),
        .pixel         (pixel),
        .ref_color     (ref2),
        .cos_threshold (cos_threshold),
        .match         (match_second)
    );

    // Valid bits follow each word through the angle pipeline.
    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;

    always_comb
    begin
        valid_next = {valid_reg[PIPE_DEPTH-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The pixel itself is delayed alongside, for pass-through.
    pixel_t pixel_reg [PIPE_DEPTH];

    always_ff @(posedge clk)
    begin
        pixel_reg[0] <= pixel;
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            pixel_reg[i] <= pixel_reg[i-1];
        end
    end

    // Words in flight, used by the top level for credit.
    always_comb
    begin
        front_stat.count = '0;
        for (int i = 0; i < PIPE_DEPTH; i++)
        begin
            front_stat.count = front_stat.count + PCNT_W'(valid_reg[i]);
        end
    end

    assign item.pixel        = pixel_reg[PIPE_DEPTH-1];
    assign item.match_first  = match_first;
    assign item.match_second = match_second;
    assign item_valid        = valid_reg[PIPE_DEPTH-1];

endmodule

/* hdl/cap_queue.sv */
module cap_queue
    import cap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       push_item,
    input  logic        pop,
    output item_t       head,
    output queue_stat_t stat
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for the queued words.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

/* hdl/cap_back.sv */
module cap_back
    import cap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   head,
    input  logic    head_valid,
    output logic    pop,
    output result_t result,
    output logic    done
);

    result_t result_next, result_reg;
    logic    done_reg;

    // The receiver never stalls, so the head word is taken whenever present.
    assign pop = head_valid;

    // Paint red on a second-reference match, green on a first-only match.
    always_comb
    begin
        result_next.match_first  = head.match_first;
        result_next.match_second = head.match_second;
        if (head.match_second)
        begin
            result_next.out_red   = PAINT_FULL;
            result_next.out_green = '0;
            result_next.out_blue  = '0;
        end
        else if (head.match_first)
        begin
            result_next.out_red   = '0;
            result_next.out_green = PAINT_FULL;
            result_next.out_blue  = '0;
        end
        else
        begin
            result_next.out_red   = head.pixel.pixel_red;
            result_next.out_green = head.pixel.pixel_green;
            result_next.out_blue  = head.pixel.pixel_blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* hdl/color_angle_pixel_classifier.sv */
// Colour-angle pixel classifier.
// A pixel word is taken at a rising edge where start is high and busy is low;
// one pixel may be offered every cycle. Each pixel gives exactly one result
// word on result, marked by done for a single cycle, in the order of entry.
// The receiver cannot hold results off: each result is taken at the edge
// that ends its done cycle.
// From the accepting edge to the result, a word passes through four stages
// of angle arithmetic (the norm product times the squared cosine is split
// into two multiplies), one queue slot and the output register. Throughput
// is one pixel per clock while busy is low.
// busy rises only if words in the arithmetic pipeline and the queue would
// exceed their joint capacity; since the back end drains every cycle, it
// stays low in normal use.
// Reference colours and cos_threshold are written via cfg_we, cfg_index and
// cfg_data, by the user only while no pixel is in flight: the block does not
// enforce it. Unknown indices are ignored. Reset sets the references to black,
// the threshold to 32270 (about ten degrees) and empties pipeline and queue.
`include "color_angle_pixel_classifier_macros.svh"

module color_angle_pixel_classifier
    import cap_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pixel_t                 pixel,
    output result_t                result,
    output logic                   done,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    ref_color_t        ref1_reg, ref2_reg;
    logic [COS_W-1:0]  cos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref1_reg <= '0;
            ref2_reg <= '0;
            cos_reg  <= COS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_REF1_RED:      ref1_reg.red   <= cfg_data[CHAN_W-1:0];
                REG_REF1_GREEN:    ref1_reg.green <= cfg_data[CHAN_W-1:0];
                REG_REF1_BLUE:     ref1_reg.blue  <= cfg_data[CHAN_W-1:0];
                REG_REF2_RED:      ref2_reg.red   <= cfg_data[CHAN_W-1:0];
                REG_REF2_GREEN:    ref2_reg.green <= cfg_data[CHAN_W-1:0];
                REG_REF2_BLUE:     ref2_reg.blue  <= cfg_data[CHAN_W-1:0];
                REG_COS_THRESHOLD: cos_reg        <= cfg_data[COS_W-1:0];
                default:           ;
            endcase
        end
    end

    // Credit check over the pipeline and the queue.
    front_stat_t        front_stat;
    queue_stat_t        q_stat;
    logic [TOKEN_W-1:0] tokens;
    logic               accepted;

    assign tokens   = TOKEN_W'(front_stat.count) + TOKEN_W'(q_stat.count);
    assign busy     = (tokens >= TOKEN_W'(CAPACITY));
    assign accepted = start && !busy;

    // Front end: angle classification.
    item_t front_item;
    logic  push_valid;

    cap_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accepted),
        .pixel         (pixel),
        .ref1          (ref1_reg),
        .ref2          (ref2_reg),
        .cos_threshold (cos_reg),
        .item          (front_item),
        .item_valid    (push_valid),
        .front_stat    (front_stat)
    );

    // Queue between the two ends.
    item_t head;
    logic  pop;

    cap_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // Back end: painting and result register.
    cap_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .result     (result),
        .done       (done)
    );

    // Checks on painting, queue occupancy and pipeline tracking.
    `CAP_ASSERT_SAME(a_red_paint, done && result.match_second, result.out_red == PAINT_FULL && result.out_green == '0 && result.out_blue == '0)
    `CAP_ASSERT_SAME(a_green_paint, done && result.match_first && !result.match_second, result.out_red == '0 && result.out_green == PAINT_FULL && result.out_blue == '0)
    `CAP_ASSERT_SAME(a_queue_no_overflow, push_valid && !pop, !q_stat.full)
    `CAP_ASSERT_NEXT(a_accept_tracked, accepted, front_stat.count != '0)

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import cap_pkg::*;

    // Index with no register behind it; writes to it must leave the block unchanged.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [COS_W-1:0] COS_MINUS_ONE = 16'hFFFF;
    localparam logic [COS_W-1:0] COS_MOST_NEG  = 16'h8000;
    localparam logic [COS_W-1:0] COS_ALMOST_ONE = 16'h7FFF;
    localparam logic [COS_W-1:0] COS_ZERO      = 16'h0000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_PHASES = 12;
    localparam int REPORT_LIMIT  = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    pixel_t                 pixel;
    result_t                result;
    logic                   done;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Local copy of the classifier settings.
    ref_color_t       first_colour;
    ref_color_t       second_colour;
    logic [COS_W-1:0] cos_limit;

    pixel_t  pixel_backlog[$];
    result_t expected_results[$];
    int      words_in_flight;
    int      idle_left;
    int      idle_percent;
    int      error_count;
    logic    taken;

    color_angle_pixel_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .result    (result),
        .done      (done),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Angle test without an inverse cosine: squared dot product against
    // squared cosine times both squared norms, in wide unsigned arithmetic.
    function automatic logic within_angle(pixel_t p, ref_color_t rc, logic [COS_W-1:0] cos_q);
        logic [71:0] pr, pg, pb, rr, rg, rb;
        logic [71:0] p2, r2, d, c, lhs, rhs;
        pr = 72'(p.pixel_red);
        pg = 72'(p.pixel_green);
        pb = 72'(p.pixel_blue);
        rr = 72'(rc.red);
        rg = 72'(rc.green);
        rb = 72'(rc.blue);
        p2 = pr * pr + pg * pg + pb * pb;
        r2 = rr * rr + rg * rg + rb * rb;
        d  = pr * rr + pg * rg + pb * rb;
        if (p2 == 0 || r2 == 0)
            return 1'b0;
        // A negative cosine is always exceeded, since the dot product cannot be negative.
        if (cos_q[COS_W-1])
            return 1'b1;
        c   = 72'(cos_q);
        lhs = (d * d) << FRAC_W;
        rhs = c * c * p2 * r2;
        return lhs > rhs;
    endfunction

    // Expected output word for one pixel under the current settings.
    function automatic result_t classify_pixel(pixel_t p);
        result_t r;
        r.match_first  = within_angle(p, first_colour, cos_limit);
        r.match_second = within_angle(p, second_colour, cos_limit);
        if (r.match_second)
        begin
            r.out_red   = PAINT_FULL;
            r.out_green = '0;
            r.out_blue  = '0;
        end
        else if (r.match_first)
        begin
            r.out_red   = '0;
            r.out_green = PAINT_FULL;
            r.out_blue  = '0;
        end
        else
        begin
            r.out_red   = p.pixel_red;
            r.out_green = p.pixel_green;
            r.out_blue  = p.pixel_blue;
        end
        return r;
    endfunction

    function automatic pixel_t make_pixel(int r, int g, int b);
        pixel_t p;
        p.pixel_red   = r[7:0];
        p.pixel_green = g[7:0];
        p.pixel_blue  = b[7:0];
        return p;
    endfunction

    function automatic ref_color_t make_colour(int r, int g, int b);
        ref_color_t rc;
        rc.red   = r[7:0];
        rc.green = g[7:0];
        rc.blue  = b[7:0];
        return rc;
    endfunction

    function automatic int clamp_channel(int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // A pixel pointing roughly along a reference colour, at a random brightness.
    function automatic pixel_t near_colour(ref_color_t rc);
        int scale;
        int r, g, b;
        scale = $urandom_range(1, 255);
        r = clamp_channel(int'(rc.red) * scale / 255 + int'($urandom_range(0, 12)) - 6);
        g = clamp_channel(int'(rc.green) * scale / 255 + int'($urandom_range(0, 12)) - 6);
        b = clamp_channel(int'(rc.blue) * scale / 255 + int'($urandom_range(0, 12)) - 6);
        return make_pixel(r, g, b);
    endfunction

    function automatic ref_color_t pick_colour();
        case ($urandom_range(0, 7))
            0: return make_colour(0, 0, 0);
            1: return make_colour(255, 0, 0);
            2: return make_colour(0, 255, 0);
            3: return make_colour(0, 0, 255);
            4: return make_colour(255, 255, 255);
            default: return make_colour($urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255));
        endcase
    endfunction

    // Thresholds are mostly cosines of angles below about 52 degrees.
    function automatic logic [COS_W-1:0] pick_threshold();
        case ($urandom_range(0, 11))
            0: return COS_ZERO;
            1: return COS_ALMOST_ONE;
            2: return COS_MOST_NEG;
            3: return COS_MINUS_ONE;
            4: return COS_RESET;
            5: return COS_W'($urandom_range(0, 65535));
            default: return COS_W'($urandom_range(20000, 32767));
        endcase
    endfunction

    // One register write, mirrored into the local settings at the same edge.
    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_REF1_RED:      first_colour.red    = value[CHAN_W-1:0];
            REG_REF1_GREEN:    first_colour.green  = value[CHAN_W-1:0];
            REG_REF1_BLUE:     first_colour.blue   = value[CHAN_W-1:0];
            REG_REF2_RED:      second_colour.red   = value[CHAN_W-1:0];
            REG_REF2_GREEN:    second_colour.green = value[CHAN_W-1:0];
            REG_REF2_BLUE:     second_colour.blue  = value[CHAN_W-1:0];
            REG_COS_THRESHOLD: cos_limit           = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Full set of registers; the unused upper byte of each colour write is noise.
    task automatic load_settings(ref_color_t a, ref_color_t b, logic [COS_W-1:0] thr);
        write_register(REG_REF1_RED,   {8'($urandom), a.red});
        write_register(REG_REF1_GREEN, {8'($urandom), a.green});
        write_register(REG_REF1_BLUE,  {8'($urandom), a.blue});
        write_register(REG_REF2_RED,   {8'($urandom), b.red});
        write_register(REG_REF2_GREEN, {8'($urandom), b.green});
        write_register(REG_REF2_BLUE,  {8'($urandom), b.blue});
        write_register(REG_COS_THRESHOLD, thr);
        write_register(REG_UNUSED, 16'($urandom));
    endtask

    // Waits until every word sent has come back, then lets the pipeline settle.
    task automatic drain();
        do
            @(negedge clk);
        while (pixel_backlog.size() != 0 || words_in_flight != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic queue_pixel(int r, int g, int b);
        pixel_backlog.push_back(make_pixel(r, g, b));
    endtask

    // Driver: offers the next pixel word at the falling edge, with random idle bursts.
    always @(negedge clk)
    begin
        if (!rst_n || (start && !taken))
        begin
            // Hold the current word until it is taken.
        end
        else if (idle_left != 0)
        begin
            idle_left = idle_left - 1;
            start <= 1'b0;
        end
        else if (pixel_backlog.size() != 0)
        begin
            if (idle_percent != 0 && $urandom_range(0, 99) < idle_percent)
            begin
                idle_left = $urandom_range(0, 15);
                start <= 1'b0;
            end
            else
            begin
                pixel <= pixel_backlog.pop_front();
                start <= 1'b1;
                words_in_flight = words_in_flight + 1;
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Prediction on acceptance and checking of each result word.
    always @(posedge clk)
    begin
        result_t exp_word;
        taken <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            expected_results.push_back(classify_pixel(pixel));
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                error_count = error_count + 1;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result word %h", result);
            end
            else
            begin
                exp_word = expected_results.pop_front();
                words_in_flight = words_in_flight - 1;
                if (result.out_red !== exp_word.out_red
                    || result.out_green !== exp_word.out_green
                    || result.out_blue !== exp_word.out_blue
                    || result.match_first !== exp_word.match_first
                    || result.match_second !== exp_word.match_second)
                begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_LIMIT)
                        $display({"mismatch: exp rgb %0d %0d %0d m1 %b m2 %b,",
                                  " got rgb %0d %0d %0d m1 %b m2 %b"},
                                 exp_word.out_red, exp_word.out_green, exp_word.out_blue,
                                 exp_word.match_first, exp_word.match_second,
                                 result.out_red, result.out_green, result.out_blue,
                                 result.match_first, result.match_second);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        int phase;
        int count;
        int pick;
        ref_color_t a;
        ref_color_t b;
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        pixel           = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        taken           = 1'b0;
        words_in_flight = 0;
        idle_left       = 0;
        idle_percent    = 20;
        error_count     = 0;
        first_colour    = '0;
        second_colour   = '0;
        cos_limit       = COS_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Settings straight after reset: black references match nothing.
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(85, 170, 15);
        drain();

        // Green and red references at the reset threshold of about ten degrees.
        load_settings(make_colour(0, 255, 0), make_colour(255, 0, 0), COS_RESET);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(250, 20, 0);
        queue_pixel(20, 250, 0);
        queue_pixel(255, 50, 0);
        queue_pixel(1, 0, 0);
        drain();

        // Threshold of minus one: any nonzero pair matches, a black reference never does.
        load_settings(make_colour(0, 0, 255), make_colour(0, 0, 0), COS_MINUS_ONE);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 0, 0);
        queue_pixel(17, 3, 200);
        drain();

        // Threshold of zero: only a positive dot product matches.
        load_settings(make_colour(255, 0, 0), make_colour(0, 255, 255), COS_ZERO);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 0, 0);
        queue_pixel(1, 1, 1);
        drain();

        // Threshold just below one: only nearly parallel colours match.
        load_settings(make_colour(255, 255, 255), make_colour(128, 128, 128), COS_ALMOST_ONE);
        queue_pixel(255, 255, 255);
        queue_pixel(7, 7, 7);
        queue_pixel(255, 255, 254);
        drain();

        // Most negative threshold.
        load_settings(make_colour(1, 0, 0), make_colour(0, 0, 0), COS_MOST_NEG);
        queue_pixel(0, 0, 0);
        queue_pixel(0, 255, 0);
        drain();

        // Random phases; the last one runs without idle cycles.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            a = pick_colour();
            b = ($urandom_range(0, 9) == 0) ? a : pick_colour();
            load_settings(a, b, pick_threshold());
            case ($urandom_range(0, 2))
                0: idle_percent = 0;
                1: idle_percent = 10;
                default: idle_percent = 40;
            endcase
            if (phase == RANDOM_PHASES - 1)
                idle_percent = 0;
            count = $urandom_range(120, 190);
            repeat (count)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    pixel_backlog.push_back(near_colour(first_colour));
                else if (pick < 6)
                    pixel_backlog.push_back(near_colour(second_colour));
                else if (pick == 6)
                    pixel_backlog.push_back(make_pixel($urandom_range(0, 1) * 255,
                                                       $urandom_range(0, 1) * 255,
                                                       $urandom_range(0, 1) * 255));
                else
                    pixel_backlog.push_back(make_pixel($urandom_range(0, 255),
                                                       $urandom_range(0, 255),
                                                       $urandom_range(0, 255)));
            end
            drain();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* color_angle_pixel_classifier.f */
+incdir+hdl
hdl/cap_pkg.sv
hdl/cap_angle.sv
hdl/cap_front.sv
hdl/cap_queue.sv
hdl/cap_back.sv
hdl/color_angle_pixel_classifier.sv
dv/testbench.sv
